>>> hdl/jqe_pkg.sv
// ----------------------------------------------------------------------------
// jqe_pkg
// Shared types and constants for the quintic Julia escape-time pixel block.
// ----------------------------------------------------------------------------
`default_nettype none

package jqe_pkg;

	localparam int PIX_W     = 12;
	localparam int REG_W     = 32;
	localparam int LIMIT_W   = 12;
	localparam int CNT_OUT_W = 12;
	localparam int COLOR_W   = 8;
	localparam int CFG_IDX_W = 3;
	localparam int OP_W      = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_X_MIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_X_STEP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_C_REAL     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 3'd6;

	// register reset values
	localparam logic signed [REG_W-1:0] X_MIN_RST  = -32'sd33554432;
	localparam logic signed [REG_W-1:0] Y_MIN_RST  = -32'sd33554432;
	localparam logic signed [REG_W-1:0] X_STEP_RST = 32'sd65536;
	localparam logic signed [REG_W-1:0] Y_STEP_RST = 32'sd65536;
	localparam logic signed [REG_W-1:0] C_REAL_RST = 32'sd13421773;
	localparam logic signed [REG_W-1:0] C_IMAG_RST = 32'sd10066330;
	localparam logic [LIMIT_W-1:0]      LIMIT_RST  = 12'd1000;

	// accumulator operations carried with each product
	localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD_A = 3'd1;
	localparam logic [OP_W-1:0] OP_ADD_A  = 3'd2;
	localparam logic [OP_W-1:0] OP_SUB_A  = 3'd3;
	localparam logic [OP_W-1:0] OP_LOAD_B = 3'd4;
	localparam logic [OP_W-1:0] OP_ADD_B  = 3'd5;

	// colour banding
	localparam logic [CNT_OUT_W-1:0] BAND_1 = 12'd250;
	localparam logic [CNT_OUT_W-1:0] BAND_2 = 12'd500;
	localparam logic [CNT_OUT_W-1:0] BAND_3 = 12'd750;
	localparam logic [COLOR_W-1:0]   COLOR_FACTOR = 8'd25;
	localparam logic [COLOR_W-1:0]   OFS_1 = 8'd251;
	localparam logic [COLOR_W-1:0]   OFS_2 = 8'(501);
	localparam logic [COLOR_W-1:0]   OFS_3 = 8'(751);
	localparam logic [COLOR_W-1:0]   WHITE = 8'd255;
	localparam int                   HALF_BASE = 502;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_col;
		logic [PIX_W-1:0] pixel_row;
	} pixel_t;

	typedef struct packed {
		logic signed [REG_W-1:0] point_real;
		logic signed [REG_W-1:0] point_imag;
		logic [CNT_OUT_W-1:0]    escape_count;
		logic [COLOR_W-1:0]      red;
		logic [COLOR_W-1:0]      green;
		logic [COLOR_W-1:0]      blue;
	} result_t;

	typedef struct packed {
		logic            valid;
		logic [OP_W-1:0] op;
	} mul_ctl_t;

endpackage

`default_nettype wire

>>> hdl/jqe_mul.sv
// ----------------------------------------------------------------------------
// jqe_mul
// Two-stage signed multiplier, built from four half-width partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module jqe_mul #(
	parameter int COORD_BITS = 32
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  jqe_pkg::mul_ctl_t              in_ctl,
	input  wire logic signed [COORD_BITS-1:0] a,
	input  wire logic signed [COORD_BITS-1:0] b,
	output jqe_pkg::mul_ctl_t              out_ctl,
	output logic signed [2*COORD_BITS-1:0] prod
);

	localparam int LO = COORD_BITS / 2;
	localparam int HI = COORD_BITS - LO;
	localparam int PW = 2 * COORD_BITS;

	logic signed [HI-1:0]    a_hi, b_hi;
	logic [LO-1:0]           a_lo, b_lo;
	logic signed [2*HI-1:0]  hh;
	logic signed [HI+LO:0]   hl, lh;
	logic [2*LO-1:0]         ll;

	logic signed [2*HI-1:0]  hh_s1;
	logic signed [HI+LO:0]   hl_s1, lh_s1;
	logic [2*LO-1:0]         ll_s1;
	jqe_pkg::mul_ctl_t       ctl_s1;

	logic [PW-1:0]           sum;

	always_comb begin
		a_hi = a[COORD_BITS-1:LO];
		b_hi = b[COORD_BITS-1:LO];
		a_lo = a[LO-1:0];
		b_lo = b[LO-1:0];
		hh   = a_hi * b_hi;
		hl   = a_hi * signed'({1'b0, b_lo});
		lh   = b_hi * signed'({1'b0, a_lo});
		ll   = a_lo * b_lo;
	end

	always_ff @(posedge clk) begin
		hh_s1 <= hh;
		hl_s1 <= hl;
		lh_s1 <= lh;
		ll_s1 <= ll;
	end

	// a*b = hh<<2LO + (hl+lh)<<LO + ll, exact in 2*COORD_BITS bits
	always_comb begin
		sum = (PW'(hh_s1) << (2 * LO)) + ((PW'(hl_s1) + PW'(lh_s1)) << LO) + PW'(ll_s1);
	end

	always_ff @(posedge clk) begin
		prod <= signed'(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			out_ctl <= '0;
		end else begin
			ctl_s1  <= in_ctl;
			out_ctl <= ctl_s1;
		end
	end

endmodule

`default_nettype wire

>>> hdl/julia_quintic_escape_pixel.sv
// ----------------------------------------------------------------------------
// julia_quintic_escape_pixel
// Escape-time evaluator for z <- z^5 + c over one pixel at a time.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (pixel_valid / pixel_stall / pixel) takes one pixel item.
//    pixel_stall is high while an item is being worked on; a new item is
//    taken as soon as the previous one has been moved to the result register.
//  - Result channel (result_valid / result_stall / result) holds one item in
//    an output register; the block starts the next pixel while it waits.
//    If the result register is still full at the end of a pixel, the block
//    waits until it is taken.
//  - Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
//    ready; write it only while no pixel is in flight. Unknown indexes are
//    dropped.
//  - One shared multiplier forms every real product; each iteration is
//    one escape test and four complex products, the four real products of
//    each issued back to back.
//  - Reset (arst_n low) loads the default plane and constant, limit 1000,
//    and leaves the block idle with no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module julia_quintic_escape_pixel #(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS  = 24,
	parameter int COUNT_BITS = 12
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   pixel_valid,
	output logic                                  pixel_stall,
	input  jqe_pkg::pixel_t                       pixel,
	output logic                                  result_valid,
	input  wire                                   result_stall,
	output jqe_pkg::result_t                      result,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [jqe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [jqe_pkg::REG_W-1:0]        cfg_data
);

	localparam int C      = COORD_BITS;
	localparam int ACC_W  = 2 * COORD_BITS + 2;
	localparam int TH_BIT = 2 * FRAC_BITS + 2;
	localparam bit TH_FITS = (TH_BIT <= ACC_W - 2);
	localparam logic signed [ACC_W-1:0] THRESH =
		TH_FITS ? signed'(ACC_W'(1) << TH_BIT) : '0;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MAP  = 3'd1;
	localparam logic [2:0] S_ESC  = 3'd2;
	localparam logic [2:0] S_CMUL = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	// step at which the accumulator holds the last product of a phase
	localparam logic [2:0] FIN_SHORT = 3'd4;
	localparam logic [2:0] FIN_CMUL  = 3'd6;
	localparam logic [1:0] PW_LAST   = 2'd3;

	logic [2:0] state_q, cnt_q;
	logic [1:0] pw_q;
	logic [COUNT_BITS-1:0] n_q;
	logic res_valid_q;

	logic signed [jqe_pkg::REG_W-1:0] x_min_q, y_min_q, x_step_q, y_step_q;
	logic signed [jqe_pkg::REG_W-1:0] c_real_q, c_imag_q;
	logic [jqe_pkg::LIMIT_W-1:0]      iteration_limit_q;

	logic [jqe_pkg::PIX_W-1:0] col_q, row_q;
	logic signed [C-1:0] zr_q, zi_q, wr_q, wi_q, p_re_q, p_im_q;
	logic signed [ACC_W-1:0] acc_a_q, acc_b_q;
	jqe_pkg::result_t res_q, res_next;

	logic signed [C-1:0] x_min_c, y_min_c, x_step_c, y_step_c, cr_c, ci_c;
	logic signed [C-1:0] col_ext, row_ext, nar_a, nar_b;
	logic [COUNT_BITS-1:0] limit_c;
	logic in_disk, fin, res_free;

	jqe_pkg::mul_ctl_t mi_ctl, mo_ctl;
	logic signed [C-1:0] mul_a, mul_b;
	logic signed [2*C-1:0] mul_p;
	logic signed [ACC_W-1:0] mul_ext;

	logic [jqe_pkg::CNT_OUT_W-1:0] k;
	logic [jqe_pkg::COLOR_W-1:0]   k8, lin, fac1, fac2, fac3, half8;
	logic signed [13:0]            hv, hq;

	assign pixel_stall  = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign res_free     = !res_valid_q || !result_stall;

	always_comb begin
		x_min_c  = C'(x_min_q);
		y_min_c  = C'(y_min_q);
		x_step_c = C'(x_step_q);
		y_step_c = C'(y_step_q);
		cr_c     = C'(c_real_q);
		ci_c     = C'(c_imag_q);
		limit_c  = COUNT_BITS'(iteration_limit_q);
		col_ext  = signed'(C'(col_q));
		row_ext  = signed'(C'(row_q));
		nar_a    = C'(acc_a_q >>> FRAC_BITS);
		nar_b    = C'(acc_b_q >>> FRAC_BITS);
		in_disk  = !TH_FITS || (acc_a_q <= THRESH);
		mul_ext  = ACC_W'(mul_p);
		fin      = (state_q == S_CMUL) ? (cnt_q == FIN_CMUL) : (cnt_q == FIN_SHORT);
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mi_ctl = '0;
		case (state_q)
			S_MAP: begin
				case (cnt_q)
					3'd0: begin
						mi_ctl = '{valid: 1'b1, op: jqe_pkg::OP_LOAD_A};
						mul_a  = x_step_c;
						mul_b  = col_ext;
					end
					3'd1: begin
						mi_ctl = '{valid: 1'b1, op: jqe_pkg::OP_LOAD_B};
						mul_a  = y_step_c;
						mul_b  = row_ext;
					end
					default: ;
				endcase
			end
			S_ESC: begin
				case (cnt_q)
					3'd0: begin
						mi_ctl = '{valid: 1'b1, op: jqe_pkg::OP_LOAD_A};
						mul_a  = zr_q;
						mul_b  = zr_q;
					end
					3'd1: begin
						mi_ctl = '{valid: 1'b1, op: jqe_pkg::OP_ADD_A};
						mul_a  = zi_q;
						mul_b  = zi_q;
					end
					default: ;
				endcase
			end
			S_CMUL: begin
				case (cnt_q)
					3'd0: begin
						mi_ctl = '{valid: 1'b1, op: jqe_pkg::OP_LOAD_A};
						mul_a  = wr_q;
						mul_b  = zr_q;
					end
					3'd1: begin
						mi_ctl = '{valid: 1'b1, op: jqe_pkg::OP_SUB_A};
						mul_a  = wi_q;
						mul_b  = zi_q;
					end
					3'd2: begin
						mi_ctl = '{valid: 1'b1, op: jqe_pkg::OP_LOAD_B};
						mul_a  = wr_q;
						mul_b  = zi_q;
					end
					3'd3: begin
						mi_ctl = '{valid: 1'b1, op: jqe_pkg::OP_ADD_B};
						mul_a  = wi_q;
						mul_b  = zr_q;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	jqe_mul #(
		.COORD_BITS(COORD_BITS)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (mi_ctl),
		.a       (mul_a),
		.b       (mul_b),
		.out_ctl (mo_ctl),
		.prod    (mul_p)
	);

	// colour bands; every formula only needs its low byte
	always_comb begin
		k     = jqe_pkg::CNT_OUT_W'(n_q);
		k8    = k[jqe_pkg::COLOR_W-1:0];
		lin   = jqe_pkg::OFS_1 - {k8[jqe_pkg::COLOR_W-2:0], 1'b0};
		fac1  = 8'((jqe_pkg::OFS_1 - k8) * jqe_pkg::COLOR_FACTOR);
		fac2  = 8'((jqe_pkg::OFS_2 - k8) * jqe_pkg::COLOR_FACTOR);
		fac3  = 8'((jqe_pkg::OFS_3 - k8) * jqe_pkg::COLOR_FACTOR);
		hv    = 14'(jqe_pkg::HALF_BASE) - signed'({2'b00, k});
		// halve, rounding toward zero
		hq    = (hv + signed'({13'd0, hv[13]})) >>> 1;
		half8 = hq[jqe_pkg::COLOR_W-1:0];

		res_next.point_real   = jqe_pkg::REG_W'(p_re_q);
		res_next.point_imag   = jqe_pkg::REG_W'(p_im_q);
		res_next.escape_count = k;
		if (k < jqe_pkg::BAND_1) begin
			res_next.red   = fac1;
			res_next.green = lin;
			res_next.blue  = half8;
		end else if (k < jqe_pkg::BAND_2) begin
			res_next.red   = lin;
			res_next.green = half8;
			res_next.blue  = fac2;
		end else if (k < jqe_pkg::BAND_3) begin
			res_next.red   = half8;
			res_next.green = fac3;
			res_next.blue  = lin;
		end else begin
			res_next.red   = jqe_pkg::WHITE;
			res_next.green = jqe_pkg::WHITE;
			res_next.blue  = jqe_pkg::WHITE;
		end
	end

	// sequencer, counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			cnt_q             <= '0;
			pw_q              <= '0;
			n_q               <= '0;
			res_valid_q       <= 1'b0;
			x_min_q           <= jqe_pkg::X_MIN_RST;
			y_min_q           <= jqe_pkg::Y_MIN_RST;
			x_step_q          <= jqe_pkg::X_STEP_RST;
			y_step_q          <= jqe_pkg::Y_STEP_RST;
			c_real_q          <= jqe_pkg::C_REAL_RST;
			c_imag_q          <= jqe_pkg::C_IMAG_RST;
			iteration_limit_q <= jqe_pkg::LIMIT_RST;
		end else begin
			if (state_q == S_DONE && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pixel_valid) begin
						state_q <= S_MAP;
						cnt_q   <= '0;
					end
				end
				S_MAP: begin
					if (fin) begin
						state_q <= S_ESC;
						cnt_q   <= '0;
						n_q     <= '0;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_ESC: begin
					if (fin) begin
						cnt_q <= '0;
						pw_q  <= '0;
						state_q <= (n_q < limit_c && in_disk) ? S_CMUL : S_DONE;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_CMUL: begin
					if (fin) begin
						cnt_q <= '0;
						if (pw_q == PW_LAST) begin
							n_q     <= n_q + COUNT_BITS'(1);
							state_q <= S_ESC;
						end else begin
							pw_q <= pw_q + 2'd1;
						end
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_DONE: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_valid) begin
				case (cfg_index)
					jqe_pkg::CFG_X_MIN:      x_min_q  <= signed'(cfg_data);
					jqe_pkg::CFG_Y_MIN:      y_min_q  <= signed'(cfg_data);
					jqe_pkg::CFG_X_STEP:     x_step_q <= signed'(cfg_data);
					jqe_pkg::CFG_Y_STEP:     y_step_q <= signed'(cfg_data);
					jqe_pkg::CFG_C_REAL:     c_real_q <= signed'(cfg_data);
					jqe_pkg::CFG_C_IMAG:     c_imag_q <= signed'(cfg_data);
					jqe_pkg::CFG_ITER_LIMIT:
						iteration_limit_q <= cfg_data[jqe_pkg::LIMIT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && pixel_valid) begin
			col_q <= pixel.pixel_col;
			row_q <= pixel.pixel_row;
		end
		if (state_q == S_MAP && fin) begin
			zr_q   <= x_min_c + signed'(acc_a_q[C-1:0]);
			zi_q   <= y_min_c + signed'(acc_b_q[C-1:0]);
			p_re_q <= x_min_c + signed'(acc_a_q[C-1:0]);
			p_im_q <= y_min_c + signed'(acc_b_q[C-1:0]);
		end
		if (state_q == S_ESC && fin) begin
			wr_q <= zr_q;
			wi_q <= zi_q;
		end
		if (state_q == S_CMUL && fin) begin
			wr_q <= nar_a;
			wi_q <= nar_b;
			if (pw_q == PW_LAST) begin
				zr_q <= nar_a + cr_c;
				zi_q <= nar_b + ci_c;
			end
		end
		if (mo_ctl.valid) begin
			case (mo_ctl.op)
				jqe_pkg::OP_LOAD_A: acc_a_q <= mul_ext;
				jqe_pkg::OP_ADD_A:  acc_a_q <= acc_a_q + mul_ext;
				jqe_pkg::OP_SUB_A:  acc_a_q <= acc_a_q - mul_ext;
				jqe_pkg::OP_LOAD_B: acc_b_q <= mul_ext;
				jqe_pkg::OP_ADD_B:  acc_b_q <= acc_b_q + mul_ext;
				default: ;
			endcase
		end
		if (state_q == S_DONE && res_free) begin
			res_q <= res_next;
		end
	end

	// no product may still be in flight once the block is idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mo_ctl.valid)
		else $error("multiplier result arrived while idle");

	// the count never passes the limit while iterating
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ESC || state_q == S_CMUL) |-> (n_q <= limit_c))
		else $error("iteration count beyond limit");

	// an accepted item starts the coordinate mapping
	assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && !pixel_stall) |=> (state_q == S_MAP && cnt_q == 3'd0))
		else $error("accepted item did not start mapping");

	// a finished item lands in the result register and frees the input
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_free) |=> (res_valid_q && state_q == S_IDLE))
		else $error("finished item not delivered");

endmodule

`default_nettype wire

>>> test/julia_quintic_escape_pixel_tb.sv
// ----------------------------------------------------------------------------
// julia_quintic_escape_pixel_tb
// Self-checking bench for the quintic Julia escape-time pixel block. A local
// fixed-point model predicts point, count and colour for every accepted pixel
// item; results are checked in order. Directed plane/limit sweeps come first,
// then randomized planes and constants under varying idle and stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module julia_quintic_escape_pixel_tb;

	localparam logic [jqe_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int FRAC = 24;
	// |z|^2 <= 4 in Q.48 after squaring
	localparam logic [64:0] ESCAPE_MAG = 65'd1 << (2 * FRAC + 2);
	localparam int HOLD_CYCLES = 600;

	typedef struct {
		logic [jqe_pkg::REG_W-1:0] x_min, y_min, x_step, y_step, c_real, c_imag;
		logic [jqe_pkg::REG_W-1:0] limit_word;
	} cfg_set_t;

	class escape_ledger;
		logic signed [jqe_pkg::REG_W-1:0] x_min, y_min, x_step, y_step, c_real, c_imag;
		logic [jqe_pkg::LIMIT_W-1:0] iter_limit;
		jqe_pkg::result_t pending[$];
		int faults;

		function new();
			x_min = jqe_pkg::X_MIN_RST;
			y_min = jqe_pkg::Y_MIN_RST;
			x_step = jqe_pkg::X_STEP_RST;
			y_step = jqe_pkg::Y_STEP_RST;
			c_real = jqe_pkg::C_REAL_RST;
			c_imag = jqe_pkg::C_IMAG_RST;
			iter_limit = jqe_pkg::LIMIT_RST;
			faults = 0;
		endfunction

		function void write_register(logic [jqe_pkg::CFG_IDX_W-1:0] idx,
				logic [jqe_pkg::REG_W-1:0] data);
			case (idx)
				jqe_pkg::CFG_X_MIN: x_min = data;
				jqe_pkg::CFG_Y_MIN: y_min = data;
				jqe_pkg::CFG_X_STEP: x_step = data;
				jqe_pkg::CFG_Y_STEP: y_step = data;
				jqe_pkg::CFG_C_REAL: c_real = data;
				jqe_pkg::CFG_C_IMAG: c_imag = data;
				jqe_pkg::CFG_ITER_LIMIT: iter_limit = data[jqe_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		endfunction

		function jqe_pkg::result_t evaluate_pixel(jqe_pkg::pixel_t p);
			jqe_pkg::result_t r;
			logic signed [jqe_pkg::REG_W-1:0] zr, zi, wr, wi;
			logic signed [63:0] ar, ai, br, bi, re_w, im_w;
			logic [63:0] sq_r, sq_i;
			logic [64:0] mag;
			logic [jqe_pkg::CNT_OUT_W-1:0] n;
			int k, h;
			r.point_real = x_min + 32'(p.pixel_col) * x_step;
			r.point_imag = y_min + 32'(p.pixel_row) * y_step;
			zr = r.point_real;
			zi = r.point_imag;
			n = '0;
			while (n < iter_limit) begin
				ar = zr;
				ai = zi;
				sq_r = ar * ar;
				sq_i = ai * ai;
				mag = {1'b0, sq_r} + {1'b0, sq_i};
				if (mag > ESCAPE_MAG)
					break;
				// z^5 built left to right, one truncating shift per complex product
				wr = zr;
				wi = zi;
				repeat (4) begin
					ar = wr;
					ai = wi;
					br = zr;
					bi = zi;
					re_w = ar * br - ai * bi;
					im_w = ar * bi + ai * br;
					wr = re_w[FRAC+jqe_pkg::REG_W-1:FRAC];
					wi = im_w[FRAC+jqe_pkg::REG_W-1:FRAC];
				end
				zr = wr + c_real;
				zi = wi + c_imag;
				n++;
			end
			r.escape_count = n;
			k = int'(n);
			h = (jqe_pkg::HALF_BASE - k) / 2;
			if (k < 250) begin
				r.red = 8'(25 * (251 - k));
				r.green = 8'(251 - 2 * k);
				r.blue = 8'(h);
			end else if (k < 500) begin
				r.red = 8'(251 - 2 * k);
				r.green = 8'(h);
				r.blue = 8'(25 * (501 - k));
			end else if (k < 750) begin
				r.red = 8'(h);
				r.green = 8'(25 * (751 - k));
				r.blue = 8'(251 - 2 * k);
			end else begin
				r.red = jqe_pkg::WHITE;
				r.green = jqe_pkg::WHITE;
				r.blue = jqe_pkg::WHITE;
			end
			return r;
		endfunction

		function void note_pixel(jqe_pkg::pixel_t p);
			pending.push_back(evaluate_pixel(p));
		endfunction

		function void check_result(jqe_pkg::result_t got);
			jqe_pkg::result_t want;
			string diff;
			if (pending.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result item: re=%h im=%h n=%0d", got.point_real,
						got.point_imag, got.escape_count);
				return;
			end
			want = pending.pop_front();
			diff = "";
			if (got.point_real !== want.point_real) diff = {diff, " point_real"};
			if (got.point_imag !== want.point_imag) diff = {diff, " point_imag"};
			if (got.escape_count !== want.escape_count) diff = {diff, " escape_count"};
			if (got.red !== want.red) diff = {diff, " red"};
			if (got.green !== want.green) diff = {diff, " green"};
			if (got.blue !== want.blue) diff = {diff, " blue"};
			if (diff != "") begin
				faults++;
				if (faults <= 10)
					$display("mismatch on%s: exp re=%h im=%h n=%0d rgb=%h%h%h,",
						diff, want.point_real, want.point_imag, want.escape_count,
						want.red, want.green, want.blue,
						" got re=%h im=%h n=%0d rgb=%h%h%h", got.point_real,
						got.point_imag, got.escape_count, got.red, got.green, got.blue);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pixel_valid = 1'b0;
	logic pixel_stall;
	jqe_pkg::pixel_t pixel = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	jqe_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [jqe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [jqe_pkg::REG_W-1:0] cfg_data = '0;

	escape_ledger ledger = new();
	int tx_idle_pct = 36;
	int rx_idle_pct = 45;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;

	julia_quintic_escape_pixel u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel(pixel),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: random stalls, plus one long hold-off to back up the pipe
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			result_stall <= 1'b1;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (result_valid && !result_stall)
			ledger.check_result(result);
	end

	task automatic send_pixel(input logic [jqe_pkg::PIX_W-1:0] col,
			input logic [jqe_pkg::PIX_W-1:0] row);
		jqe_pkg::pixel_t p;
		p.pixel_col = col;
		p.pixel_row = row;
		if ($urandom_range(99) < tx_idle_pct) begin
			pixel_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		pixel <= p;
		pixel_valid <= 1'b1;
		do @(posedge clk); while (pixel_stall);
		ledger.note_pixel(p);
	endtask

	task automatic settle();
		pixel_valid <= 1'b0;
		while (ledger.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [jqe_pkg::CFG_IDX_W-1:0] idx,
			input logic [jqe_pkg::REG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		ledger.write_register(idx, data);
	endtask

	task automatic load_setup(input cfg_set_t s);
		write_reg(jqe_pkg::CFG_X_MIN, s.x_min);
		write_reg(jqe_pkg::CFG_Y_MIN, s.y_min);
		write_reg(jqe_pkg::CFG_X_STEP, s.x_step);
		write_reg(jqe_pkg::CFG_Y_STEP, s.y_step);
		write_reg(jqe_pkg::CFG_C_REAL, s.c_real);
		write_reg(jqe_pkg::CFG_C_IMAG, s.c_imag);
		write_reg(jqe_pkg::CFG_ITER_LIMIT, s.limit_word);
		write_reg(CFG_UNUSED, $urandom());
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int setups, input int items);
		cfg_set_t s;
		int w, h, half_x, half_y;
		logic [jqe_pkg::PIX_W-1:0] col, row;
		logic [jqe_pkg::LIMIT_W-1:0] lim;
		for (int k = 0; k < setups; k++) begin
			w = $urandom_range(4095, 16);
			h = $urandom_range(4095, 16);
			// plane half-width between 1.2 and 2.2
			half_x = $urandom_range(36909875, 20132659);
			half_y = $urandom_range(36909875, 20132659);
			s.x_min = -half_x;
			s.y_min = -half_y;
			s.x_step = (2 * half_x) / w;
			s.y_step = (2 * half_y) / h;
			s.c_real = int'($urandom_range(36909876)) - 18454938;
			s.c_imag = int'($urandom_range(36909876)) - 18454938;
			if ($urandom_range(5) == 0)
				lim = 12'($urandom_range(260, 100));
			else
				lim = 12'($urandom_range(48, 1));
			// upper bits of the limit word are don't-care
			s.limit_word = {20'($urandom()), lim};
			if ($urandom_range(7) == 0) begin
				s.x_min = $urandom();
				s.y_min = $urandom();
				s.x_step = $urandom();
				s.y_step = $urandom();
				s.c_real = $urandom();
				s.c_imag = $urandom();
				w = 4096;
				h = 4096;
			end
			load_setup(s);
			for (int i = 0; i < items; i++) begin
				if ($urandom_range(3) == 0) begin
					col = 12'($urandom());
					row = 12'($urandom());
				end else begin
					col = 12'($urandom_range(w - 1));
					row = 12'($urandom_range(h - 1));
				end
				send_pixel(col, row);
			end
			settle();
		end
	endtask

	initial begin
		cfg_set_t s;
		logic [jqe_pkg::REG_W-1:0] limits[9];
		limits = '{32'd249, 32'd250, 32'd499, 32'd500, 32'd749, 32'd750,
			32'd4095, 32'h0000_1000, 32'd1};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset plane and constant
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd512, 12'd512);
		send_pixel(12'd4095, 12'd0);
		settle();

		// c = 0 around the origin: points in the unit disk never escape,
		// so the count lands exactly on the limit (band edges, max, zero)
		s.x_min = '0;
		s.y_min = '0;
		s.x_step = 32'd65536;
		s.y_step = 32'd65536;
		s.c_real = '0;
		s.c_imag = '0;
		foreach (limits[i]) begin
			s.limit_word = limits[i];
			if (limits[i] == 32'd1)
				hold_req <= 1'b1;
			load_setup(s);
			send_pixel(12'd0, 12'd0);
			if (limits[i] == 32'd250 || limits[i] == 32'd750 || limits[i] == 32'h0000_1000
					|| limits[i] == 32'd1)
				send_pixel(12'd100, 12'd50);
			if (limits[i] == 32'd4095 || limits[i] == 32'd1)
				send_pixel(12'd600, 12'd0);
			if (limits[i] == 32'd1)
				send_pixel(12'd4095, 12'd4095);
			settle();
		end

		// register extremes: mapping and +c wrap around
		s.x_min = 32'h8000_0000;
		s.y_min = 32'h7FFF_FFFF;
		s.x_step = 32'h7FFF_FFFF;
		s.y_step = 32'h8000_0000;
		s.c_real = 32'h7FFF_FFFF;
		s.c_imag = 32'h8000_0000;
		s.limit_word = 32'hFFFF_FFFF;
		load_setup(s);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1, 12'd1);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd1, 12'd0);
		send_pixel(12'd2, 12'd3);
		settle();

		random_phase(4, 17);
		tx_idle_pct = 45;
		rx_idle_pct <= 36;
		random_phase(4, 17);
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		random_phase(4, 17);

		settle();
		repeat (40) @(posedge clk);
		if (ledger.faults == 0 && ledger.pending.size() == 0)
			$display("julia_quintic_escape_pixel regression: pass");
		else
			$display("julia_quintic_escape_pixel regression: fail");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("julia_quintic_escape_pixel regression: fail");
		$finish;
	end

endmodule
